// File: hw/rtl/kgm_pkg.sv
// Package for the key gesture menu navigator: request payload types, gesture
// kinds, key codes and register indexes.
// Depends on nothing; every other file of the block uses it.
package kgm_pkg;

  localparam int NUM_KEYS_DEF = 4;
  localparam int LINE_BITS    = 4;
  localparam int KEY_W        = 2;
  localparam int TIME_W       = 16;
  localparam int CNT_W        = 16;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam logic [KEY_W-1:0] KEY_NONE = 2'd0;
  localparam logic [KEY_W-1:0] KEY_PREV = 2'd1;
  localparam logic [KEY_W-1:0] KEY_FWD  = 2'd2;
  localparam logic [KEY_W-1:0] KEY_OK   = 2'd3;

  localparam logic [1:0] REG_KEEP_THR  = 2'd0;
  localparam logic [1:0] REG_DCLICK    = 2'd1;
  localparam logic [1:0] REG_LAST_LINE = 2'd2;

  localparam logic [TIME_W-1:0]    KEEP_THR_RST  = 16'd20;
  localparam logic [TIME_W-1:0]    DCLICK_RST    = 16'd300;
  localparam logic [LINE_BITS-1:0] LAST_LINE_RST = 4'd0;

  typedef enum logic [2:0] {
    EV_PRESS    = 3'd0,
    EV_KEEP     = 3'd1,
    EV_CLICK    = 3'd2,
    EV_DOUBLE   = 3'd3,
    EV_LONG_END = 3'd4
  } ev_kind_t;

  typedef struct packed {
    logic              valid;
    ev_kind_t          kind;
    logic [KEY_W-1:0]  key;
  } gesture_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_code;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic                 event_valid;
    logic [2:0]           event_kind;
    logic [KEY_W-1:0]     event_key;
    logic                 activate;
    logic [LINE_BITS-1:0] selected_line;
    logic [LINE_BITS-1:0] first_line;
    logic [KEY_W-1:0]     held_key;
  } out_item_t;

endpackage

// File: hw/rtl/kgm_gesture.sv
// Gesture classifier: held key, saturating repeat count and per-key click history.
// Depends on kgm_pkg.
module kgm_gesture #(
  parameter int NUM_KEYS = kgm_pkg::NUM_KEYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic [kgm_pkg::KEY_W-1:0]   key_code,
  input  logic [kgm_pkg::TIME_W-1:0]  now_time,
  input  logic [kgm_pkg::TIME_W-1:0]  keep_thr,
  input  logic [kgm_pkg::TIME_W-1:0]  dclick_win,
  output kgm_pkg::gesture_t           gesture,
  output logic [kgm_pkg::KEY_W-1:0]   held_nxt
);

  localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [kgm_pkg::KEY_W-1:0]  held_r;
  logic [kgm_pkg::CNT_W-1:0]  cnt_r;
  logic [kgm_pkg::CNT_W-1:0]  cnt_nxt;
  logic [kgm_pkg::TIME_W-1:0] click_time_r [NUM_KEYS];
  logic [NUM_KEYS-1:0]        seen_r;

  logic [KIDX_W-1:0]          kidx;
  logic                       in_range;
  logic                       store;
  logic                       seen;
  logic [kgm_pkg::TIME_W-1:0] dt;

  assign kidx     = KIDX_W'(held_r);
  assign in_range = (int'(held_r) < NUM_KEYS);

  always_comb begin
    held_nxt       = held_r;
    cnt_nxt        = cnt_r;
    gesture.valid  = 1'b0;
    gesture.kind   = kgm_pkg::EV_PRESS;
    gesture.key    = kgm_pkg::KEY_NONE;
    store          = 1'b0;
    seen           = in_range && seen_r[kidx];
    dt             = now_time - click_time_r[kidx];
    if (key_code != kgm_pkg::KEY_NONE) begin
      if (key_code == held_r) begin
        cnt_nxt = (cnt_r == '1) ? cnt_r : cnt_r + 16'd1;
      end else begin
        held_nxt      = key_code;
        cnt_nxt       = 16'd1;
        gesture.valid = 1'b1;
        gesture.kind  = kgm_pkg::EV_PRESS;
        gesture.key   = key_code;
      end
      if ((cnt_nxt > keep_thr) && (cnt_nxt[1:0] == 2'b00)) begin
        gesture.valid = 1'b1;
        gesture.kind  = kgm_pkg::EV_KEEP;
        gesture.key   = key_code;
      end
    end else begin
      if (held_r != kgm_pkg::KEY_NONE) begin
        gesture.valid = 1'b1;
        gesture.key   = held_r;
        if (cnt_r < keep_thr) begin
          gesture.kind = (seen && (dt < dclick_win)) ? kgm_pkg::EV_DOUBLE
                                                     : kgm_pkg::EV_CLICK;
          store        = in_range;
        end else begin
          gesture.kind = kgm_pkg::EV_LONG_END;
        end
      end
      held_nxt = kgm_pkg::KEY_NONE;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= kgm_pkg::KEY_NONE;
      cnt_r  <= '0;
      seen_r <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        click_time_r[i] <= '0;
      end
    end else if (advance) begin
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
      if (store) begin
        seen_r[kidx]       <= 1'b1;
        click_time_r[kidx] <= now_time;
      end
    end
  end

endmodule

// File: hw/rtl/kgm_cursor.sv
// Menu cursor: moves the selected line on previous and next gestures with
// wraparound, and derives the first visible line. Depends on kgm_pkg.
module kgm_cursor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  kgm_pkg::gesture_t               gesture,
  input  logic [kgm_pkg::LINE_BITS-1:0]   last_line,
  output logic [kgm_pkg::LINE_BITS-1:0]   sel_nxt,
  output logic [kgm_pkg::LINE_BITS-1:0]   first_nxt
);

  logic [kgm_pkg::LINE_BITS-1:0] sel_r;
  logic [kgm_pkg::LINE_BITS:0]   inc;

  always_comb begin
    sel_nxt = sel_r;
    inc     = {1'b0, sel_r};
    if (gesture.valid) begin
      case (gesture.key)
        kgm_pkg::KEY_PREV: begin
          if (gesture.kind != kgm_pkg::EV_CLICK) begin
            sel_nxt = (sel_r == '0) ? last_line : sel_r - 1'b1;
          end
        end
        kgm_pkg::KEY_FWD: begin
          if (gesture.kind != kgm_pkg::EV_CLICK) begin
            inc = {1'b0, sel_r} + 1'b1;
          end
          sel_nxt = (inc > {1'b0, last_line}) ? '0 : inc[kgm_pkg::LINE_BITS-1:0];
        end
        default: sel_nxt = sel_r;
      endcase
    end
    first_nxt = (sel_nxt >= 2) ? sel_nxt - 2'd2 : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;
    end else if (advance) begin
      sel_r <= sel_nxt;
    end
  end

endmodule

// File: hw/rtl/key_gesture_menu_navigator.sv
// Top level of the key gesture menu navigator: request registers, configuration
// port and result register. Depends on kgm_pkg, kgm_gesture and kgm_cursor.
//
// One key scan request yields exactly one result. A request is accepted every
// cycle while the result side keeps up: it is captured in an input register,
// classified and applied to the cursor once the result register can take it,
// and held in a result register until taken, so throughput is one request per
// cycle. Registers sit at byte addresses 0 (keep-press threshold),
// 4 (double-click window) and 8 (last line) and are to be written while idle.
module key_gesture_menu_navigator #(
  parameter int NUM_KEYS = kgm_pkg::NUM_KEYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  kgm_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output kgm_pkg::out_item_t            out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [kgm_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [kgm_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [kgm_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  logic [kgm_pkg::TIME_W-1:0]    keep_thr_r;
  logic [kgm_pkg::TIME_W-1:0]    dclick_r;
  logic [kgm_pkg::LINE_BITS-1:0] last_line_r;

  logic                          req_vld_r;
  kgm_pkg::in_item_t             req_r;
  logic                          out_vld_r;
  kgm_pkg::out_item_t            out_r;
  logic                          advance;

  kgm_pkg::gesture_t             gesture;
  logic [kgm_pkg::KEY_W-1:0]     held_nxt;
  logic [kgm_pkg::LINE_BITS-1:0] sel_nxt;
  logic [kgm_pkg::LINE_BITS-1:0] first_nxt;
  logic                          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_thr_r  <= kgm_pkg::KEEP_THR_RST;
      dclick_r    <= kgm_pkg::DCLICK_RST;
      last_line_r <= kgm_pkg::LAST_LINE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        kgm_pkg::REG_KEEP_THR:  keep_thr_r  <= cfg_pwdata[kgm_pkg::TIME_W-1:0];
        kgm_pkg::REG_DCLICK:    dclick_r    <= cfg_pwdata[kgm_pkg::TIME_W-1:0];
        kgm_pkg::REG_LAST_LINE: last_line_r <= cfg_pwdata[kgm_pkg::LINE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      kgm_pkg::REG_KEEP_THR:  cfg_prdata = kgm_pkg::DATA_W'(keep_thr_r);
      kgm_pkg::REG_DCLICK:    cfg_prdata = kgm_pkg::DATA_W'(dclick_r);
      kgm_pkg::REG_LAST_LINE: cfg_prdata = kgm_pkg::DATA_W'(last_line_r);
      default:                cfg_prdata = '0;
    endcase
  end

  assign advance   = req_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !req_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        req_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (advance) begin
      out_r.event_valid   <= gesture.valid;
      out_r.event_kind    <= gesture.valid ? gesture.kind : 3'd0;
      out_r.event_key     <= gesture.valid ? gesture.key : kgm_pkg::KEY_NONE;
      out_r.activate      <= gesture.valid && (gesture.key == kgm_pkg::KEY_OK);
      out_r.selected_line <= sel_nxt;
      out_r.first_line    <= first_nxt;
      out_r.held_key      <= held_nxt;
    end
  end

  kgm_gesture #(
    .NUM_KEYS (NUM_KEYS)
  ) u_gesture (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .key_code   (req_r.key_code),
    .now_time   (req_r.now_time),
    .keep_thr   (keep_thr_r),
    .dclick_win (dclick_r),
    .gesture    (gesture),
    .held_nxt   (held_nxt)
  );

  kgm_cursor u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .gesture   (gesture),
    .last_line (last_line_r),
    .sel_nxt   (sel_nxt),
    .first_nxt (first_nxt)
  );

endmodule
